// File: sv/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants
// Item structs, queue entry, pipeline sideband and register map.
// ----------------------------------------------------------------------------
package mtt_pkg;

   localparam int SQ_STEPS   = 34;            // root bits
   localparam int SQ_LAT     = SQ_STEPS + 1;
   localparam int DV_STEPS   = 33;            // quotient bits
   localparam int DV_LAT     = DV_STEPS + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // 0.025 in Q32.32, rounded down
   localparam logic [66:0] SNAP_LIMIT = 67'd107374182;

   localparam logic        RST_MOVING_ENABLED = 1'b0;
   localparam logic [16:0] RST_ARRIVE_EPSILON = 17'd66;
   localparam logic [30:0] RST_SPEED          = 31'd65536;
   localparam logic [16:0] RST_TIME_STEP      = 17'd1092;

   typedef enum logic [1:0] {
      CSR_MOVING_ENABLED,
      CSR_ARRIVE_EPSILON,
      CSR_SPEED,
      CSR_TIME_STEP
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] dest_x;
      logic signed [31:0] dest_y;
      logic signed [31:0] dest_z;
      logic               has_destination;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic               arrived;
      logic               position_written;
   } rsp_type;

   // classified item, front to back
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] dest;
      logic [2:0]       neg;
      logic [2:0][32:0] mag;
      logic             written;
      logic             arrived;
   } cmd_type;

   // sideband that rides beside the root unit
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] dest;
      logic [2:0]       neg;
      logic [2:0][63:0] prod;
      logic             written;
      logic             arrived;
      logic             snap;
   } mid_type;

   // sideband that rides beside the dividers
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] dest;
      logic [2:0]       neg;
      logic             written;
      logic             arrived;
      logic             snap;
   } late_type;

endpackage

// File: sv/mtt_front.sv
// ----------------------------------------------------------------------------
// mtt_front: intake and classify
// Registers an item, forms axis deltas and magnitudes, flags arrival.
// ----------------------------------------------------------------------------
module mtt_front import mtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic        moving_enabled,
   input  logic [16:0] arrive_epsilon,
   output logic        push,
   output cmd_type     cmd
);

   logic    vld_ff, vld_in;
   req_type req_ff;

   logic [2:0][31:0] pos, dest;
   logic [2:0][32:0] diff;
   logic [2:0]       near;
   logic             active;

   assign vld_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         req_ff <= req;
      end
   end

   always_comb begin
      pos[0]  = req_ff.pos_x;
      pos[1]  = req_ff.pos_y;
      pos[2]  = req_ff.pos_z;
      dest[0] = req_ff.dest_x;
      dest[1] = req_ff.dest_y;
      dest[2] = req_ff.dest_z;
      active  = req_ff.has_destination & moving_enabled;
      for (int i = 0; i < 3; i++) begin
         diff[i]    = {dest[i][31], dest[i]} - {pos[i][31], pos[i]};
         cmd.neg[i] = diff[i][32];
         cmd.mag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
         near[i]    = cmd.mag[i] < {16'd0, arrive_epsilon};
      end
      cmd.pos     = pos;
      cmd.dest    = dest;
      cmd.written = active;
      cmd.arrived = active & (&near);
   end

   assign push = vld_ff;

endmodule

// File: sv/mtt_fifo.sv
// ----------------------------------------------------------------------------
// mtt_fifo: command queue
// Short queue between front and back; the back drains it every cycle.
// ----------------------------------------------------------------------------
module mtt_fifo import mtt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   output logic    rvalid,
   output cmd_type rdata,
   output logic    room
);

   cmd_type              mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 pop;

   assign rvalid = cnt_ff != '0;
   assign pop    = rvalid;
   assign rdata  = mem[rd_ff];
   // one slot kept for the item held in the front register
   assign room   = cnt_ff < (FIFO_AW+1)'(FIFO_DEPTH - 1);

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= wdata;
      end
   end

endmodule

// File: sv/mtt_sqrt.sv
// ----------------------------------------------------------------------------
// mtt_sqrt: pipelined integer square root
// One root bit per stage, remainder method, floor result.
// ----------------------------------------------------------------------------
module mtt_sqrt import mtt_pkg::*; (
   input  logic        clock,
   input  logic [67:0] rad,
   output logic [33:0] root
);

   logic [67:0] rad_ff  [SQ_LAT];
   logic [35:0] rem_ff  [SQ_LAT];
   logic [33:0] root_ff [SQ_LAT];
   logic [67:0] rad_in  [SQ_LAT];
   logic [35:0] rem_in  [SQ_LAT];
   logic [33:0] root_in [SQ_LAT];

   always_comb begin
      logic [35:0] r2;
      logic [35:0] trial;
      rad_in[0]  = rad;
      rem_in[0]  = '0;
      root_in[0] = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
         r2    = {rem_ff[k][33:0], rad_ff[k][67:66]};
         trial = {root_ff[k], 2'b01};
         rad_in[k+1] = {rad_ff[k][65:0], 2'b00};
         if (r2 >= trial) begin
            rem_in[k+1]  = r2 - trial;
            root_in[k+1] = {root_ff[k][32:0], 1'b1};
         end else begin
            rem_in[k+1]  = r2;
            root_in[k+1] = {root_ff[k][32:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ_LAT; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign root = root_ff[SQ_LAT-1];

endmodule

// File: sv/mtt_div.sv
// ----------------------------------------------------------------------------
// mtt_div: pipelined restoring divider
// 64-bit dividend over 33-bit divisor, one quotient bit per stage.
// Quotient must fit 33 bits; the caller guarantees it for used results.
// ----------------------------------------------------------------------------
module mtt_div import mtt_pkg::*; (
   input  logic        clock,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic [32:0] quo
);

   logic [32:0] rem_ff [DV_LAT];
   logic [32:0] low_ff [DV_LAT];
   logic [32:0] den_ff [DV_LAT];
   logic [32:0] quo_ff [DV_LAT];
   logic [32:0] rem_in [DV_LAT];
   logic [32:0] low_in [DV_LAT];
   logic [32:0] den_in [DV_LAT];
   logic [32:0] quo_in [DV_LAT];

   always_comb begin
      logic [33:0] r;
      rem_in[0] = {2'b00, num[63:33]};
      low_in[0] = num[32:0];
      den_in[0] = den;
      quo_in[0] = '0;
      for (int k = 0; k < DV_STEPS; k++) begin
         r           = {rem_ff[k], low_ff[k][32]};
         low_in[k+1] = {low_ff[k][31:0], 1'b0};
         den_in[k+1] = den_ff[k];
         if (r >= {1'b0, den_ff[k]}) begin
            rem_in[k+1] = 33'(r - {1'b0, den_ff[k]});
            quo_in[k+1] = {quo_ff[k][31:0], 1'b1};
         end else begin
            rem_in[k+1] = r[32:0];
            quo_in[k+1] = {quo_ff[k][31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DV_LAT; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         den_ff[k] <= den_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo = quo_ff[DV_LAT-1];

endmodule

// File: sv/mtt_back.sv
// ----------------------------------------------------------------------------
// mtt_back: step execution
// Squares and scaled magnitudes, distance, root, per-axis divide, saturate.
// ----------------------------------------------------------------------------
module mtt_back import mtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  cmd_type     cmd,
   input  logic [31:0] step_size,
   output logic        rsp_strobe,
   output rsp_type     rsp
);

   // stage 1: products
   logic             v1_ff;
   logic [2:0][64:0] sq_ff, sq_in;
   mid_type          m1_ff, m1_in;
   // stage 2: distance squared
   logic             v2_ff;
   logic [66:0]      dist_ff, dist_in;
   mid_type          m2_ff, m2_in;
   // delay beside root unit and dividers
   logic [SQ_LAT-1:0] vs_ff;
   mid_type           ms_ff [SQ_LAT];
   logic [DV_LAT-1:0] vd_ff;
   late_type          md_ff [DV_LAT];
   late_type          ml_in;
   logic [33:0]       root;
   logic [2:0][32:0]  quo;
   // output
   logic              out_v_ff;
   rsp_type           out_ff, out_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // magnitude is at most 2^32, which has a zero low word
         sq_in[i] = cmd.mag[i][32] ? {1'b1, 64'd0}
                                   : {1'b0, 64'(cmd.mag[i][31:0]) * 64'(cmd.mag[i][31:0])};
         m1_in.prod[i] = cmd.mag[i][32] ? {step_size, 32'd0}
                                        : cmd.mag[i][31:0] * step_size;
      end
      m1_in.pos     = cmd.pos;
      m1_in.dest    = cmd.dest;
      m1_in.neg     = cmd.neg;
      m1_in.written = cmd.written;
      m1_in.arrived = cmd.arrived;
      m1_in.snap    = 1'b0;

      dist_in    = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      m2_in      = m1_ff;
      m2_in.snap = dist_in <= SNAP_LIMIT;

      ml_in.pos     = ms_ff[SQ_LAT-1].pos;
      ml_in.dest    = ms_ff[SQ_LAT-1].dest;
      ml_in.neg     = ms_ff[SQ_LAT-1].neg;
      ml_in.written = ms_ff[SQ_LAT-1].written;
      ml_in.arrived = ms_ff[SQ_LAT-1].arrived;
      ml_in.snap    = ms_ff[SQ_LAT-1].snap;
   end

   mtt_sqrt u_sqrt (
      .clock (clock),
      .rad   ({1'b0, dist_ff}),
      .root  (root)
   );

   for (genvar a = 0; a < 3; a++) begin : g_axis
      mtt_div u_div (
         .clock (clock),
         .num   (ms_ff[SQ_LAT-1].prod[a]),
         .den   (root[32:0]),
         .quo   (quo[a])
      );
   end

   // final select and saturation
   always_comb begin
      late_type         m;
      logic [2:0][31:0] res;
      logic [34:0]      sum;
      logic [34:0]      delta;
      m = md_ff[DV_LAT-1];
      for (int i = 0; i < 3; i++) begin
         delta = m.neg[i] ? (35'd0 - {2'b00, quo[i]}) : {2'b00, quo[i]};
         sum   = {{3{m.pos[i][31]}}, m.pos[i]} + delta;
         if (!m.written || m.arrived) begin
            res[i] = m.pos[i];
         end else if (m.snap) begin
            res[i] = m.dest[i];
         end else if (!sum[34] && (sum[33:31] != 3'b000)) begin
            res[i] = 32'h7fff_ffff;
         end else if (sum[34] && (sum[33:31] != 3'b111)) begin
            res[i] = 32'h8000_0000;
         end else begin
            res[i] = sum[31:0];
         end
      end
      out_in.new_x            = res[0];
      out_in.new_y            = res[1];
      out_in.new_z            = res[2];
      out_in.arrived          = m.arrived;
      out_in.position_written = m.written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vs_ff    <= '0;
         vd_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         vs_ff    <= {vs_ff[SQ_LAT-2:0], v2_ff};
         vd_ff    <= {vd_ff[DV_LAT-2:0], vs_ff[SQ_LAT-1]};
         out_v_ff <= vd_ff[DV_LAT-1];
      end
      sq_ff    <= sq_in;
      m1_ff    <= m1_in;
      dist_ff  <= dist_in;
      m2_ff    <= m2_in;
      ms_ff[0] <= m2_ff;
      for (int k = 1; k < SQ_LAT; k++) begin
         ms_ff[k] <= ms_ff[k-1];
      end
      md_ff[0] <= ml_in;
      for (int k = 1; k < DV_LAT; k++) begin
         md_ff[k] <= md_ff[k-1];
      end
      out_ff <= out_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp        = out_ff;

endmodule

// File: sv/move_toward_target_step.sv
// ----------------------------------------------------------------------------
// move_toward_target_step: constant-speed move toward a destination
// Top level: register file, intake, command queue and step pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the item is taken on any edge where
//   busy is low. One item per cycle is accepted indefinitely while busy stays low.
//   Each item yields exactly one result, shown on rsp_data for one cycle
//   with rsp_strobe high. The receiver must take it; there is no stall.
//   From accept to strobe an item passes through the intake register,
//   queue, product stage, distance stage, a 35-stage root pipeline and a
//   34-stage divider pipeline, then the saturation register.
//   Throughput is one item per clock; the queue drains every cycle, so
//   busy stays low in normal use.
//   Registers (APB, byte address 4*i): moving_enabled, arrive_epsilon,
//   speed, time_step. Write them only while no items are in flight.
//   The step size speed*time_step is precomputed in the cycle after a write.
//   Synchronous reset empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module move_toward_target_step import mtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // item intake
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   // results
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   // registers
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        moving_enabled_ff;
   logic [16:0] arrive_epsilon_ff;
   logic [30:0] speed_ff;
   logic [16:0] time_step_ff;
   logic [31:0] step_ff, step_in;
   logic [47:0] step_full;

   logic          csr_wr;
   csr_index_type csr_idx;
   logic          accept;
   logic          push, q_valid, q_room;
   cmd_type       push_cmd, q_cmd;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = csr_index_type'(paddr[3:2]);

   // step size per frame, Q16.16
   assign step_full = speed_ff * time_step_ff;
   assign step_in   = step_full[47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_enabled_ff <= RST_MOVING_ENABLED;
         arrive_epsilon_ff <= RST_ARRIVE_EPSILON;
         speed_ff          <= RST_SPEED;
         time_step_ff      <= RST_TIME_STEP;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_MOVING_ENABLED: moving_enabled_ff <= pwdata[0];
            CSR_ARRIVE_EPSILON: arrive_epsilon_ff <= pwdata[16:0];
            CSR_SPEED:          speed_ff          <= pwdata[30:0];
            CSR_TIME_STEP:      time_step_ff      <= pwdata[16:0];
            default: ;
         endcase
      end
      step_ff <= step_in;
   end

   always_comb begin
      unique case (csr_idx)
         CSR_MOVING_ENABLED: prdata = {31'd0, moving_enabled_ff};
         CSR_ARRIVE_EPSILON: prdata = {15'd0, arrive_epsilon_ff};
         CSR_SPEED:          prdata = {1'b0, speed_ff};
         CSR_TIME_STEP:      prdata = {15'd0, time_step_ff};
         default:            prdata = '0;
      endcase
   end

   // intake stalls only if the queue has no room
   assign busy   = !q_room;
   assign accept = start & !busy;

   mtt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .moving_enabled (moving_enabled_ff),
      .arrive_epsilon (arrive_epsilon_ff),
      .push           (push),
      .cmd            (push_cmd)
   );

   mtt_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (push_cmd),
      .rvalid (q_valid),
      .rdata  (q_cmd),
      .room   (q_room)
   );

   mtt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .cmd        (q_cmd),
      .step_size  (step_ff),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // arrival is only reported for a processed entity
   a_arrive_written: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.arrived |-> rsp_data.position_written)
      else $error("arrival without position write");

   // queue drains every cycle, so intake never backs up
   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("command queue backed up");
`endif

endmodule

// File: bench/move_toward_target_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// move_toward_target_step_tb: self-checking bench for the step block
// Drives directed and random entities under several register settings,
// predicts each result in the bench and compares every field in order.
// ----------------------------------------------------------------------------
module move_toward_target_step_tb;
   import mtt_pkg::*;

   localparam int LATENCY = 74;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // bench copy of the register file
   logic        cfg_moving;
   logic [16:0] cfg_epsilon;
   logic [30:0] cfg_speed;
   logic [16:0] cfg_time_step;

   rsp_type expected_moves[$];
   int      error_count = 0;

   always #6 clock = ~clock;

   move_toward_target_step i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // floor square root of a value below 2^68
   function automatic logic [33:0] root_floor(input logic [67:0] n);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({34'd0, c} * {34'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic rsp_type predict_move(input req_type it);
      logic signed [32:0] pos[3];
      logic signed [32:0] dif[3];
      logic [32:0]        mag[3];
      logic signed [63:0] res[3];
      logic [67:0]        dist_sq;
      logic [33:0]        len;
      logic [63:0]        step_size;
      logic [63:0]        st;
      logic               near;
      rsp_type            r;
      pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
      dif[0] = it.dest_x - pos[0];
      dif[1] = it.dest_y - pos[1];
      dif[2] = it.dest_z - pos[2];
      r = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = dif[i] < 0 ? -dif[i] : dif[i];
         res[i] = pos[i];
      end
      if (it.has_destination && cfg_moving) begin
         r.position_written = 1'b1;
         near = 1'b1;
         for (int i = 0; i < 3; i++)
            if (mag[i] >= {16'd0, cfg_epsilon}) near = 1'b0;
         if (near) begin
            r.arrived = 1'b1;
         end else begin
            dist_sq = '0;
            for (int i = 0; i < 3; i++) dist_sq += {35'd0, mag[i]} * {35'd0, mag[i]};
            len = root_floor(dist_sq);
            if (dist_sq <= 68'd107374182 || len == 0) begin
               for (int i = 0; i < 3; i++) res[i] = pos[i] + dif[i];
            end else begin
               step_size = ({33'd0, cfg_speed} * {47'd0, cfg_time_step}) >> 16;
               for (int i = 0; i < 3; i++) begin
                  // |d| < 2^33 and s < 2^32, product fits 65 bits: use 96
                  st = 64'(({63'd0, mag[i]} * {32'd0, step_size}) / {62'd0, len});
                  res[i] = pos[i] + (dif[i] < 0 ? -$signed(st) : $signed(st));
                  if (res[i] > 64'sd2147483647) res[i] = 64'sd2147483647;
                  if (res[i] < -64'sd2147483648) res[i] = -64'sd2147483648;
               end
            end
         end
      end
      r.new_x = res[0][31:0];
      r.new_y = res[1][31:0];
      r.new_z = res[2][31:0];
      return r;
   endfunction

   // result checker: every strobe pops the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_moves.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.new_x, 32'h0);
         end else begin
            rsp_type w;
            w = expected_moves.pop_front();
            if (rsp_data.new_x !== w.new_x) report_mismatch("new_x", rsp_data.new_x, w.new_x);
            if (rsp_data.new_y !== w.new_y) report_mismatch("new_y", rsp_data.new_y, w.new_y);
            if (rsp_data.new_z !== w.new_z) report_mismatch("new_z", rsp_data.new_z, w.new_z);
            if (rsp_data.arrived !== w.arrived)
               report_mismatch("arrived", rsp_data.arrived, w.arrived);
            if (rsp_data.position_written !== w.position_written)
               report_mismatch("position_written", rsp_data.position_written,
                               w.position_written);
         end
      end
   end

   task automatic idle_cycles(input int n);
      repeat (n) @(posedge clock);
   endtask

   // random gap, mostly short, now and then long; start drops during it
   task automatic random_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (r < 50) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         idle_cycles(n);
      end
   endtask

   // start stays high after the item so the next one can follow at once
   task automatic send_item(input req_type it, input bit with_gaps);
      if (with_gaps) random_gap();
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_moves.push_back(predict_move(it));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      idle_cycles(4);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= 4'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_MOVING_ENABLED: cfg_moving    = value[0];
         CSR_ARRIVE_EPSILON: cfg_epsilon   = value[16:0];
         CSR_SPEED:          cfg_speed     = value[30:0];
         default:            cfg_time_step = value[16:0];
      endcase
      idle_cycles(2);
   endtask

   function automatic logic [31:0] random_coord();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return $urandom();
      if (k < 4) return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 65536)
                                             : 32'h8000_0000 + $urandom_range(0, 65536);
      return 32'($signed($urandom_range(0, 2000000)) - 1000000);
   endfunction

   // entity mostly aimed near its position so arrival, snap and short steps occur
   function automatic req_type random_entity();
      req_type     it;
      logic [31:0] p[3];
      logic [31:0] q[3];
      int          mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         p[i] = random_coord();
         case (mode)
            0, 1:    q[i] = p[i] + 32'($signed($urandom_range(0, 200)) - 100);
            2, 3:    q[i] = p[i] + 32'($signed($urandom_range(0, 20000)) - 10000);
            4, 5, 6: q[i] = p[i] + 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: q[i] = random_coord();
         endcase
      end
      it.pos_x = p[0]; it.pos_y = p[1]; it.pos_z = p[2];
      it.dest_x = q[0]; it.dest_y = q[1]; it.dest_z = q[2];
      it.has_destination = ($urandom_range(0, 9) != 0);
      return it;
   endfunction

   function automatic req_type make_entity(input logic [31:0] px, py, pz, dx, dy, dz,
                                           input logic hd);
      req_type it;
      it.pos_x = px; it.pos_y = py; it.pos_z = pz;
      it.dest_x = dx; it.dest_y = dy; it.dest_z = dz;
      it.has_destination = hd;
      return it;
   endfunction

   // reset values, moving still disabled: every entity idles
   task automatic test_disabled();
      send_item(make_entity(1, 2, 3, 32'h10000, 0, 0, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
      wait_drained();
   endtask

   task automatic test_directed();
      write_reg(CSR_MOVING_ENABLED, 32'h1);
      // no destination
      send_item(make_entity(5, 6, 7, 32'h7fffffff, 0, 0, 1'b0), 1'b0);
      // arrival: inside epsilon, and just at the edge on one axis
      send_item(make_entity(100, 100, 100, 130, 80, 165, 1'b1), 1'b0);
      send_item(make_entity(100, 100, 100, 166, 100, 100, 1'b1), 1'b0);
      // snap distance and just beyond it
      send_item(make_entity(0, 0, 0, 32'd10362, 0, 0, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 32'd10363, 0, 0, 1'b1), 1'b0);
      // normal steps along each axis, both signs
      send_item(make_entity(0, 0, 0, 32'h00100000, 0, 0, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 0, 32'hfff00000, 0, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 32'h30000, 32'h40000, 32'hfffb0000, 1'b1), 1'b0);
      // field extremes
      send_item(make_entity(32'h7fffffff, 32'h80000000, 0,
                            32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1), 1'b0);
      send_item(make_entity(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1), 1'b0);
      wait_drained();
      // big step: overshoot and saturation
      write_reg(CSR_SPEED, 32'hffffffff);
      write_reg(CSR_TIME_STEP, 32'h10000);
      write_reg(CSR_ARRIVE_EPSILON, 32'h0);
      send_item(make_entity(0, 0, 0, 0, 0, 0, 1'b1), 1'b0);
      send_item(make_entity(32'h7fff0000, 0, 0, 32'h7fffffff, 0, 0, 1'b1), 1'b0);
      send_item(make_entity(32'h80010000, 32'h7ff00000, 0,
                            32'h80000000, 32'h7fffffff, 1, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 32'h00020000, 32'h00020000, 0, 1'b1), 1'b0);
      wait_drained();
      // widest epsilon, zero speed and zero time step
      write_reg(CSR_ARRIVE_EPSILON, 32'hffff_ffff);
      write_reg(CSR_SPEED, 32'h0);
      write_reg(CSR_TIME_STEP, 32'h0);
      send_item(make_entity(0, 0, 0, 32'h0000ffff, 32'hffff0001, 0, 1'b1), 1'b0);
      send_item(make_entity(0, 0, 0, 32'h00010000, 0, 0, 1'b1), 1'b0);
      wait_drained();
   endtask

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         send_item(random_entity(), i % 100 < 70);
         // halfway through, the sender holds off until the pipeline has emptied
         if (i == n / 2) wait_drained();
      end
      wait_drained();
   endtask

   task automatic test_random();
      write_reg(CSR_MOVING_ENABLED, 32'h1);
      write_reg(CSR_ARRIVE_EPSILON, 32'd66);
      write_reg(CSR_SPEED, 32'h00010000);
      write_reg(CSR_TIME_STEP, 32'd1092);
      run_random(150);
      write_reg(CSR_ARRIVE_EPSILON, 32'h10000);
      write_reg(CSR_SPEED, 32'h7fffffff);
      write_reg(CSR_TIME_STEP, 32'h10000);
      run_random(120);
      write_reg(CSR_ARRIVE_EPSILON, $urandom_range(0, 4000));
      write_reg(CSR_SPEED, $urandom());
      write_reg(CSR_TIME_STEP, $urandom_range(0, 65536));
      run_random(120);
      write_reg(CSR_MOVING_ENABLED, 32'hfffffffe);
      run_random(40);
   endtask

   initial begin
      cfg_moving    = RST_MOVING_ENABLED;
      cfg_epsilon   = RST_ARRIVE_EPSILON;
      cfg_speed     = RST_SPEED;
      cfg_time_step = RST_TIME_STEP;
      idle_cycles(6);
      reset <= 1'b0;
      idle_cycles(2);
      test_disabled();
      test_directed();
      test_random();
      idle_cycles(LATENCY + 20);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
sv/mtt_pkg.sv
sv/mtt_front.sv
sv/mtt_fifo.sv
sv/mtt_sqrt.sv
sv/mtt_div.sv
sv/mtt_back.sv
sv/move_toward_target_step.sv
bench/move_toward_target_step_tb.sv
